### hdl/qsd_pkg.sv
// Shared widths and register codes for the quad signed distance block.
// No dependencies; used by qsd_root and quad_signed_distance.
package qsd_pkg;

  localparam int CW = 32;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int AW = PW + 1;
  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int NW = 2 * AW;
  localparam int RW = CW - 1;
  localparam int QW = RW + PW;
  localparam int NE = 4;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] CFG_MIN_HALF_X  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_HALF_Y      = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] CFG_TOP_LEFT_X  = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] CFG_TOP_RIGHT_X = CFG_IW'(3);

  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [AW-1:0] cross_t;

endpackage

### hdl/qsd_root.sv
// Pipelined bounded root search: largest r below 2^RW with r*r*m <= n, one bit per stage.
// Depends on qsd_pkg.
module qsd_root (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [qsd_pkg::NW-1:0]     n_i,
  input  logic [qsd_pkg::PW-1:0]     m_i,
  output logic [qsd_pkg::RW-1:0]     r_o
);

  logic [qsd_pkg::NW-1:0] rem_q  [qsd_pkg::RW];
  logic [qsd_pkg::QW-1:0] acc_q  [qsd_pkg::RW];
  logic [qsd_pkg::PW-1:0] den_q  [qsd_pkg::RW];
  logic [qsd_pkg::RW-1:0] root_q [qsd_pkg::RW];

  for (genvar k = 0; k < qsd_pkg::RW; k++) begin : g_stage
    localparam int B = qsd_pkg::RW - 1 - k;
    logic [qsd_pkg::NW-1:0] rem_in;
    logic [qsd_pkg::QW-1:0] acc_in;
    logic [qsd_pkg::PW-1:0] den_in;
    logic [qsd_pkg::RW-1:0] root_in;
    logic [qsd_pkg::NW-1:0] trial;
    logic                   fits;

    if (k == 0) begin : g_first
      assign rem_in  = n_i;
      assign acc_in  = '0;
      assign den_in  = m_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign acc_in  = acc_q[k-1];
      assign den_in  = den_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = (qsd_pkg::NW'(acc_in) << (B + 1)) + (qsd_pkg::NW'(den_in) << (2 * B));
    assign fits  = trial <= rem_in;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? rem_in - trial : rem_in;
        acc_q[k]  <= fits ? acc_in + (qsd_pkg::QW'(den_in) << B) : acc_in;
        den_q[k]  <= den_in;
        root_q[k] <= fits ? (root_in | (qsd_pkg::RW'(1) << B)) : root_in;
      end
    end
  end

  assign r_o = root_q[qsd_pkg::RW-1];

  a_zero_den_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (den_q[0] == '0) |-> root_q[0][qsd_pkg::RW-1])
    else $error("zero divisor must pass every trial bit");

endmodule

### hdl/quad_signed_distance.sv
// Top level: signed distance from a point to a trapezoid outline, deep pipeline.
// Depends on qsd_pkg and qsd_root.
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------
//  in      | in_valid_i / in_stall_o    | point_x_i, point_y_i
//  out     | out_valid_o / out_stall_i  | signed_distance_o, is_inside_o
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One point enters per cycle while the output is not stalled; the depth of the pipeline is set
// by the bit-per-stage root search, one per edge.
// A stalled output freezes the whole pipeline and stalls the input; nothing is dropped.
// Reset clears the config registers to zero and empties the pipeline. Config writes always complete.
module quad_signed_distance (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [qsd_pkg::CW-1:0]      point_x_i,
  input  logic signed [qsd_pkg::CW-1:0]      point_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [qsd_pkg::CW-1:0]      signed_distance_o,
  output logic                               is_inside_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [qsd_pkg::CFG_IW-1:0]         cfg_index_i,
  input  logic [qsd_pkg::CW-1:0]             cfg_data_i
);

  localparam int DEPTH = qsd_pkg::RW + 7;
  localparam int INS_N = DEPTH - 3;

  logic [qsd_pkg::CW-2:0]        min_half_x_q, half_y_q;
  logic signed [qsd_pkg::CW-1:0] top_left_x_q, top_right_x_q;

  logic adv;
  logic vld_q [DEPTH];
  logic ins_q [INS_N];

  qsd_pkg::diff_t  cx [qsd_pkg::NE];
  qsd_pkg::diff_t  cy [qsd_pkg::NE];
  qsd_pkg::diff_t  ex_q [qsd_pkg::NE];
  qsd_pkg::diff_t  ey_q [qsd_pkg::NE];
  qsd_pkg::diff_t  dx_q [qsd_pkg::NE];
  qsd_pkg::diff_t  dy_q [qsd_pkg::NE];
  qsd_pkg::prod_t  xdy_q [qsd_pkg::NE];
  qsd_pkg::prod_t  ydx_q [qsd_pkg::NE];
  qsd_pkg::prod_t  xdx_q [qsd_pkg::NE];
  qsd_pkg::prod_t  ydy_q [qsd_pkg::NE];
  qsd_pkg::prod_t  xx_q  [qsd_pkg::NE];
  qsd_pkg::prod_t  yy_q  [qsd_pkg::NE];
  qsd_pkg::prod_t  dxdx_q [qsd_pkg::NE];
  qsd_pkg::prod_t  dydy_q [qsd_pkg::NE];
  qsd_pkg::cross_t a_q [qsd_pkg::NE];
  qsd_pkg::cross_t s_q [qsd_pkg::NE];
  logic [qsd_pkg::PW-1:0] len2_q [qsd_pkg::NE];
  logic [qsd_pkg::PW-1:0] c2_q   [qsd_pkg::NE];
  logic [qsd_pkg::AW-1:0] amag_q [qsd_pkg::NE];
  logic                   corner4_q [qsd_pkg::NE];
  logic                   edge4_q   [qsd_pkg::NE];
  logic [qsd_pkg::PW-1:0] len24_q [qsd_pkg::NE];
  logic [qsd_pkg::PW-1:0] c24_q   [qsd_pkg::NE];
  logic [2*qsd_pkg::AH-1:0]          hh_q [qsd_pkg::NE];
  logic [qsd_pkg::AH+qsd_pkg::AL-1:0] hl_q [qsd_pkg::NE];
  logic [2*qsd_pkg::AL-1:0]          ll_q [qsd_pkg::NE];
  logic                   corner5_q [qsd_pkg::NE];
  logic                   edge5_q   [qsd_pkg::NE];
  logic [qsd_pkg::PW-1:0] len25_q [qsd_pkg::NE];
  logic [qsd_pkg::PW-1:0] c25_q   [qsd_pkg::NE];
  logic [qsd_pkg::NW-1:0] n_q [qsd_pkg::NE];
  logic [qsd_pkg::PW-1:0] m_q [qsd_pkg::NE];
  logic [qsd_pkg::RW-1:0] root [qsd_pkg::NE];

  logic                   a_neg [qsd_pkg::NE];
  logic                   a_zer [qsd_pkg::NE];
  logic                   flip;
  logic [qsd_pkg::RW-1:0] min01, min23, best;
  logic [qsd_pkg::RW-1:0] best_q;

  logic                          out_valid_q;
  logic signed [qsd_pkg::CW-1:0] signed_distance_q;
  logic                          is_inside_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_half_x_q  <= '0;
      half_y_q      <= '0;
      top_left_x_q  <= '0;
      top_right_x_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        qsd_pkg::CFG_MIN_HALF_X:  min_half_x_q  <= cfg_data_i[qsd_pkg::CW-2:0];
        qsd_pkg::CFG_HALF_Y:      half_y_q      <= cfg_data_i[qsd_pkg::CW-2:0];
        qsd_pkg::CFG_TOP_LEFT_X:  top_left_x_q  <= $signed(cfg_data_i);
        qsd_pkg::CFG_TOP_RIGHT_X: top_right_x_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    cx[0] = -$signed({2'b00, min_half_x_q});
    cx[1] = qsd_pkg::DW'(top_left_x_q);
    cx[2] = qsd_pkg::DW'(top_right_x_q);
    cx[3] = $signed({2'b00, min_half_x_q});
    cy[0] = -$signed({2'b00, half_y_q});
    cy[1] = $signed({2'b00, half_y_q});
    cy[2] = $signed({2'b00, half_y_q});
    cy[3] = -$signed({2'b00, half_y_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < DEPTH; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_comb begin
    for (int i = 0; i < qsd_pkg::NE; i++) begin
      a_neg[i] = a_q[i][qsd_pkg::AW-1];
      a_zer[i] = (a_q[i] == '0);
    end
    flip = 1'b0;
    for (int i = 1; i < qsd_pkg::NE; i++) begin
      flip = flip || (a_neg[i-1] && !a_zer[i] && !a_neg[i])
                  || (a_neg[i] && !a_zer[i-1] && !a_neg[i-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < qsd_pkg::NE; i++) begin
        ex_q[i] <= cx[i] - qsd_pkg::DW'(point_x_i);
        ey_q[i] <= cy[i] - qsd_pkg::DW'(point_y_i);
        dx_q[i] <= cx[(i + 1) % qsd_pkg::NE] - cx[i];
        dy_q[i] <= cy[(i + 1) % qsd_pkg::NE] - cy[i];

        xdy_q[i]  <= ex_q[i] * dy_q[i];
        ydx_q[i]  <= ey_q[i] * dx_q[i];
        xdx_q[i]  <= ex_q[i] * dx_q[i];
        ydy_q[i]  <= ey_q[i] * dy_q[i];
        xx_q[i]   <= ex_q[i] * ex_q[i];
        yy_q[i]   <= ey_q[i] * ey_q[i];
        dxdx_q[i] <= dx_q[i] * dx_q[i];
        dydy_q[i] <= dy_q[i] * dy_q[i];

        a_q[i]    <= qsd_pkg::AW'(xdy_q[i]) - qsd_pkg::AW'(ydx_q[i]);
        s_q[i]    <= -(qsd_pkg::AW'(xdx_q[i]) + qsd_pkg::AW'(ydy_q[i]));
        len2_q[i] <= dxdx_q[i] + dydy_q[i];
        c2_q[i]   <= xx_q[i] + yy_q[i];

        corner4_q[i] <= s_q[i][qsd_pkg::AW-1] || (s_q[i] == '0);
        edge4_q[i]   <= !s_q[i][qsd_pkg::AW-1] && (s_q[i] != '0)
                        && (s_q[i] <= $signed({1'b0, len2_q[i]}));
        amag_q[i]    <= a_q[i][qsd_pkg::AW-1] ? qsd_pkg::AW'(-a_q[i]) : qsd_pkg::AW'(a_q[i]);
        len24_q[i]   <= len2_q[i];
        c24_q[i]     <= c2_q[i];

        hh_q[i] <= amag_q[i][qsd_pkg::AW-1:qsd_pkg::AL] * amag_q[i][qsd_pkg::AW-1:qsd_pkg::AL];
        hl_q[i] <= amag_q[i][qsd_pkg::AW-1:qsd_pkg::AL] * amag_q[i][qsd_pkg::AL-1:0];
        ll_q[i] <= amag_q[i][qsd_pkg::AL-1:0] * amag_q[i][qsd_pkg::AL-1:0];
        corner5_q[i] <= corner4_q[i];
        edge5_q[i]   <= edge4_q[i];
        len25_q[i]   <= len24_q[i];
        c25_q[i]     <= c24_q[i];

        n_q[i] <= corner5_q[i] ? qsd_pkg::NW'(c25_q[i])
                  : (qsd_pkg::NW'(hh_q[i]) << (2 * qsd_pkg::AL))
                    + (qsd_pkg::NW'(hl_q[i]) << (qsd_pkg::AL + 1))
                    + qsd_pkg::NW'(ll_q[i]);
        m_q[i] <= corner5_q[i] ? qsd_pkg::PW'(1) : (edge5_q[i] ? len25_q[i] : '0);
      end
      ins_q[0] <= !flip;
      for (int k = 1; k < INS_N; k++) ins_q[k] <= ins_q[k-1];
      best_q <= best;
    end
  end

  for (genvar i = 0; i < qsd_pkg::NE; i++) begin : g_edge
    qsd_root u_root (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .n_i    (n_q[i]),
      .m_i    (m_q[i]),
      .r_o    (root[i])
    );
  end

  always_comb begin
    min01 = (root[1] < root[0]) ? root[1] : root[0];
    min23 = (root[3] < root[2]) ? root[3] : root[2];
    best  = (min23 < min01) ? min23 : min01;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      signed_distance_q <= ins_q[INS_N-1] ? -$signed({1'b0, best_q}) : $signed({1'b0, best_q});
      is_inside_q       <= ins_q[INS_N-1];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign signed_distance_o = signed_distance_q;
  assign is_inside_o       = is_inside_q;

  a_inside_not_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_inside_o |-> signed_distance_o[qsd_pkg::CW-1] || signed_distance_o == '0)
    else $error("inside point with positive distance");

  a_outside_not_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_inside_o |-> !signed_distance_o[qsd_pkg::CW-1])
    else $error("outside point with negative distance");

  a_no_most_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> signed_distance_o != {1'b1, {(qsd_pkg::CW-1){1'b0}}})
    else $error("distance reached the most negative code");

  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[DEPTH-1] |=> out_valid_o && $stable(best_q) == 1'b0 || out_valid_o)
    else $error("finished transaction did not reach the output register");

endmodule

### dv/tb_quad_signed_distance.sv
// Testbench for quad_signed_distance: directed and random points against an in-bench predictor.
// Depends on qsd_pkg and the quad_signed_distance RTL; self-checking, no external files.
`timescale 1ns / 100ps

module tb_quad_signed_distance;

  localparam int LATENCY   = qsd_pkg::RW + 8;
  localparam int WDOG_MAX  = 20000;
  localparam logic [qsd_pkg::CFG_IW-1:0] CFG_UNUSED_LO = qsd_pkg::CFG_IW'(4);

  typedef logic signed [255:0] big_t;
  typedef struct {
    logic signed [qsd_pkg::CW-1:0] sdist;
    logic                          ins;
  } dist_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [qsd_pkg::CW-1:0] point_x_i = '0;
  logic signed [qsd_pkg::CW-1:0] point_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [qsd_pkg::CW-1:0] signed_distance_o;
  logic is_inside_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [qsd_pkg::CFG_IW-1:0] cfg_index_i = '0;
  logic [qsd_pkg::CW-1:0] cfg_data_i = '0;

  dist_result_t expected_dist[$];
  int unsigned  n_errors = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  quiet_cycles = 0;

  big_t geo_min_half_x = 0;
  big_t geo_half_y = 0;
  big_t geo_top_left_x = 0;
  big_t geo_top_right_x = 0;

  quad_signed_distance u_top (.*);

  always #2 clk_i = ~clk_i;

  function automatic big_t root_floor(big_t m, big_t n);
    big_t r;
    big_t t;
    r = 0;
    for (int k = qsd_pkg::RW - 1; k >= 0; k--) begin
      t = r | (big_t'(1) <<< k);
      if (t * t * m <= n) r = t;
    end
    return r;
  endfunction

  function automatic dist_result_t predict_distance(logic signed [qsd_pkg::CW-1:0] px,
                                                    logic signed [qsd_pkg::CW-1:0] py);
    big_t cx[4];
    big_t cy[4];
    big_t x, y, dx, dy, a_cross, s_proj, len2, cand, best, prev;
    logic in_poly;
    int j;
    dist_result_t res;
    cx[0] = -geo_min_half_x;  cy[0] = -geo_half_y;
    cx[1] = geo_top_left_x;   cy[1] = geo_half_y;
    cx[2] = geo_top_right_x;  cy[2] = geo_half_y;
    cx[3] = geo_min_half_x;   cy[3] = -geo_half_y;
    best = (big_t'(1) <<< qsd_pkg::RW) - 1;
    in_poly = 1'b1;
    prev = 0;
    for (int i = 0; i < qsd_pkg::NE; i++) begin
      j = (i + 1) % qsd_pkg::NE;
      x = cx[i] - big_t'(px);
      y = cy[i] - big_t'(py);
      dx = cx[j] - cx[i];
      dy = cy[j] - cy[i];
      a_cross = x * dy - y * dx;
      s_proj = -(x * dx + y * dy);
      cand = best;
      if (s_proj <= 0) begin
        cand = root_floor(1, x * x + y * y);
      end else begin
        len2 = dx * dx + dy * dy;
        if (s_proj <= len2) cand = root_floor(len2, a_cross * a_cross);
      end
      if (cand < best) best = cand;
      if (i != 0 && in_poly) begin
        if ((prev < 0 && a_cross > 0) || (a_cross < 0 && prev > 0)) in_poly = 1'b0;
      end
      prev = a_cross;
    end
    res.sdist = in_poly ? qsd_pkg::CW'(-best) : qsd_pkg::CW'(best);
    res.ins = in_poly;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic signed [qsd_pkg::CW-1:0] got,
                                 logic signed [qsd_pkg::CW-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // receiver: random stall, check each transaction on the falling edge while it is offered and not stalled
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(negedge clk_i) begin
    dist_result_t want;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WDOG_MAX) begin
      $display("watchdog: no transaction for %0d cycles", WDOG_MAX);
      $display("tb_quad_signed_distance: errors");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_dist.size() == 0) begin
        report_mismatch("unexpected result", signed_distance_o, 0);
      end else begin
        want = expected_dist.pop_front();
        if (signed_distance_o !== want.sdist)
          report_mismatch("signed_distance", signed_distance_o, want.sdist);
        if (is_inside_o !== want.ins)
          report_mismatch("is_inside", is_inside_o, want.ins);
      end
    end
  end

  task automatic send_point(logic signed [qsd_pkg::CW-1:0] px,
                            logic signed [qsd_pkg::CW-1:0] py);
    logic acc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    do begin
      @(negedge clk_i);
      acc = !in_stall_o;
      @(posedge clk_i);
    end while (!acc);
    expected_dist.push_back(predict_distance(px, py));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_dist.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [qsd_pkg::CFG_IW-1:0] idx, logic [qsd_pkg::CW-1:0] data);
    logic acc;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      qsd_pkg::CFG_MIN_HALF_X:  geo_min_half_x = big_t'({1'b0, data[qsd_pkg::RW-1:0]});
      qsd_pkg::CFG_HALF_Y:      geo_half_y = big_t'({1'b0, data[qsd_pkg::RW-1:0]});
      qsd_pkg::CFG_TOP_LEFT_X:  geo_top_left_x = big_t'(signed'(data));
      qsd_pkg::CFG_TOP_RIGHT_X: geo_top_right_x = big_t'(signed'(data));
      default: ;
    endcase
  endtask

  task automatic set_trapezoid(logic [qsd_pkg::CW-1:0] mhx, logic [qsd_pkg::CW-1:0] hy,
                               logic [qsd_pkg::CW-1:0] tlx, logic [qsd_pkg::CW-1:0] trx);
    write_reg(qsd_pkg::CFG_MIN_HALF_X, mhx);
    write_reg(qsd_pkg::CFG_HALF_Y, hy);
    write_reg(qsd_pkg::CFG_TOP_LEFT_X, tlx);
    write_reg(qsd_pkg::CFG_TOP_RIGHT_X, trx);
  endtask

  function automatic logic signed [qsd_pkg::CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  task automatic test_reset_geometry();
    send_point(0, 0);
    send_point(qsd_pkg::CW'(1) <<< 16, -(qsd_pkg::CW'(3) <<< 16));
    send_point({1'b1, {(qsd_pkg::CW-1){1'b0}}}, {1'b0, {(qsd_pkg::CW-1){1'b1}}});
    drain_results();
  endtask

  task automatic test_extremes();
    set_trapezoid(qsd_pkg::CW'(5) <<< 16, qsd_pkg::CW'(4) <<< 16,
                  -(qsd_pkg::CW'(2) <<< 16), qsd_pkg::CW'(2) <<< 16);
    send_point(0, 0);
    send_point(qsd_pkg::CW'(1) <<< 16, qsd_pkg::CW'(1) <<< 16);
    send_point(0, qsd_pkg::CW'(4) <<< 16);
    send_point(qsd_pkg::CW'(5) <<< 16, -(qsd_pkg::CW'(4) <<< 16));
    send_point(qsd_pkg::CW'(3) <<< 16, 0);
    send_point(qsd_pkg::CW'(20) <<< 16, qsd_pkg::CW'(20) <<< 16);
    send_point({1'b1, {(qsd_pkg::CW-1){1'b0}}}, {1'b1, {(qsd_pkg::CW-1){1'b0}}});
    send_point({1'b0, {(qsd_pkg::CW-1){1'b1}}}, {1'b0, {(qsd_pkg::CW-1){1'b1}}});
    send_point(-1, -1);
    drain_results();
    set_trapezoid('1, '1, {1'b1, {(qsd_pkg::CW-1){1'b0}}}, {1'b0, {(qsd_pkg::CW-1){1'b1}}});
    send_point(0, 0);
    send_point({1'b1, {(qsd_pkg::CW-1){1'b0}}}, 0);
    send_point({1'b0, {(qsd_pkg::CW-1){1'b1}}}, {1'b1, {(qsd_pkg::CW-1){1'b0}}});
    drain_results();
  endtask

  task automatic test_zero_length_edge();
    set_trapezoid(qsd_pkg::CW'(6) <<< 16, qsd_pkg::CW'(3) <<< 16,
                  qsd_pkg::CW'(1) <<< 16, qsd_pkg::CW'(1) <<< 16);
    send_point(qsd_pkg::CW'(1) <<< 16, qsd_pkg::CW'(5) <<< 16);
    send_point(0, 0);
    send_point(qsd_pkg::CW'(1) <<< 16, qsd_pkg::CW'(3) <<< 16);
    drain_results();
    set_trapezoid(0, 0, 0, 0);
    send_point(qsd_pkg::CW'(7), -qsd_pkg::CW'(9));
    drain_results();
  endtask

  task automatic test_unused_index();
    set_trapezoid(qsd_pkg::CW'(2) <<< 16, qsd_pkg::CW'(2) <<< 16,
                  -(qsd_pkg::CW'(1) <<< 16), qsd_pkg::CW'(1) <<< 16);
    for (int k = 4; k < (1 << qsd_pkg::CFG_IW); k++) begin
      write_reg(CFG_UNUSED_LO + qsd_pkg::CFG_IW'(k - 4), '1);
    end
    send_point(0, 0);
    send_point(qsd_pkg::CW'(3) <<< 16, 0);
    drain_results();
  endtask

  task automatic test_random();
    int unsigned idle_mode[4] = '{0, 59, 0, 37};
    int unsigned stall_mode[4] = '{0, 0, 59, 37};
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = idle_mode[ph % 4];
      stall_pct = stall_mode[ph % 4];
      if (ph == 7) begin
        set_trapezoid($urandom, $urandom, $urandom, $urandom);
      end else begin
        set_trapezoid($urandom_range(0, 1 << 19), $urandom_range(0, 1 << 19),
                      $signed($urandom_range(0, 1 << 20)) - (1 << 19),
                      $signed($urandom_range(0, 1 << 20)) - (1 << 19));
      end
      for (int n = 0; n < 150; n++) begin
        send_point(rand_coord(), rand_coord());
        if (ph == 3 && n == 75) drain_results();
      end
      drain_results();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_extremes();
    test_zero_length_edge();
    test_unused_index();
    test_random();
    drain_results();
    if (n_errors == 0) begin
      $display("tb_quad_signed_distance: clean");
    end else begin
      $display("tb_quad_signed_distance: errors");
    end
    $finish;
  end

endmodule
